### rtl/slm_pkg.sv
// Package for the sorted list merge block: item kind codes and sequencer states.
// No dependencies; imported by the interfaces and the top level.
package slm_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_MERGE  = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  localparam int unsigned VALUE_W = 32;

endpackage

### rtl/slm_if.sv
// Valid/ready channel interfaces for the sorted list merge block.
// Depends on slm_pkg for the value width.
interface slm_in_if
  import slm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slm_out_if
  import slm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] merged_value;
  logic               last;
  logic               dropped;

  modport source (output valid, output merged_value, output last, output dropped,
                  input ready);
  modport sink   (input valid, input merged_value, input last, input dropped,
                  output ready);
endinterface

### rtl/sorted_list_merge.sv
// Sorted list merge top level: two list memories, a merge sequencer, output register.
// Depends on slm_pkg and the channel interfaces in slm_if.sv.
//
// Load items (kind 0 to list A, kind 1 to list B) are accepted only while idle; a load into
// a full list is dropped and sets a sticky drop flag. A merge item emits every stored
// value in ascending signed order, list B first on equal heads, one result per cycle while
// the output side keeps taking items; the input is held off until the last result is
// registered, and an empty merge emits nothing. That rate is set by the single read
// port of each list memory: the head of each list is read in the cycle before it is
// compared, and one head is consumed per result. The last result carries last=1,
// every result carries the drop flag, and the merge clears both lists and the flag.
module sorted_list_merge
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  slm_in_if.sink    in_port,
  slm_out_if.source out_port
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
  logic [VALUE_W-1:0] mem_b [LIST_DEPTH];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic             ovf_r, ovf_nxt;
  logic signed [VALUE_W-1:0] rd_a_r, rd_b_r;

  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_drop_r, out_drop_nxt;

  logic wr_a, wr_b;
  logic in_fire, adv, a_left, b_left, take_a, is_last;

  assign in_port.ready = (state_r == ST_IDLE);
  assign in_fire       = in_port.valid && in_port.ready;
  assign a_left        = (ia_r < cnt_a_r);
  assign b_left        = (ib_r < cnt_b_r);
  // strict less-than: list B wins ties
  assign take_a  = a_left && (!b_left || (rd_a_r < rd_b_r));
  assign is_last = (SUM_W'(ia_r) + SUM_W'(ib_r) + SUM_W'(1)) ==
                   (SUM_W'(cnt_a_r) + SUM_W'(cnt_b_r));
  assign adv     = (state_r == ST_MERGE) && (!out_valid_r || out_port.ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    ovf_nxt       = ovf_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    out_valid_nxt = out_valid_r && !out_port.ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_port.kind)
            KIND_LOAD_A: begin
              if (cnt_a_r < DEPTH_C) begin
                wr_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_LOAD_B: begin
              if (cnt_b_r < DEPTH_C) begin
                wr_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_MERGE: begin
              // heads at entry 0 are read on this edge
              ia_nxt = '0;
              ib_nxt = '0;
              if (cnt_a_r == '0 && cnt_b_r == '0) begin
                ovf_nxt = 1'b0;
              end else begin
                state_nxt = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = take_a ? rd_a_r : rd_b_r;
          out_last_nxt  = is_last;
          out_drop_nxt  = ovf_r;
          if (take_a) begin
            ia_nxt = ia_r + CNT_W'(1);
          end else begin
            ib_nxt = ib_r + CNT_W'(1);
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  // list memories: write at the fill count, read the next head pointer
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_port.value;
    end
    rd_a_r <= mem_a[ia_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_port.value;
    end
    rd_b_r <= mem_b[ib_nxt[AW-1:0]];
  end

  assign out_port.valid        = out_valid_r;
  assign out_port.merged_value = out_value_r;
  assign out_port.last         = out_last_r;
  assign out_port.dropped      = out_drop_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= DEPTH_C) && (cnt_b_r <= DEPTH_C))
    else $error("list count beyond depth");

  a_merge_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (a_left || b_left))
    else $error("merge running with both lists exhausted");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r))
    else $error("merge pointer past list count");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_last) |=> (state_r == ST_IDLE) && (cnt_a_r == '0) && (cnt_b_r == '0)
                         && !ovf_r && out_valid_r && out_last_r)
    else $error("merge end did not clear state");

endmodule
